@@ rtl/led_pwm_fade_sequencer_core_defines.svh @@
// Assertion macros shared by the LED PWM fade sequencer RTL.
// Each use expands to one labeled concurrent assertion on clk, disabled while arst_n is low.
`ifndef LED_PWM_FADE_SEQUENCER_CORE_DEFINES_SVH
`define LED_PWM_FADE_SEQUENCER_CORE_DEFINES_SVH

// check cons in the same cycle as ante
`define LPFS_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define LPFS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lpfs_pkg.sv @@
// Package for the LED PWM fade sequencer: constants, codes, state types and the
// command and response structs of the shared multiply/divide unit. No dependencies.
package lpfs_pkg;

	localparam int CHANNELS = 3;
	localparam int CH_W     = 2;
	localparam int PROD_W   = 49;
	localparam int CNT_W    = 6;

	localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(PROD_W - 1);
	localparam logic [15:0]      FULL_SCALE = 16'd65025;
	localparam logic [16:0]      RATE_RESET = 17'd1000;
	localparam logic [16:0]      MS_PER_S   = 17'd1000;
	localparam logic [2:0]       MASK_RESET = 3'd7;
	localparam logic [2:0]       CH_MASK    = 3'((1 << CHANNELS) - 1);

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} op_t;

	typedef enum logic {
		CFG_TICK_RATE = 1'b0,
		CFG_CHAN_MASK = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		AU_OP_MUL,
		AU_OP_MULDIV
	} au_op_t;

	typedef enum logic [1:0] {
		AU_IDLE,
		AU_MUL,
		AU_DIV
	} au_state_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MS,
		ST_T0,
		ST_T0W,
		ST_T1,
		ST_T2,
		ST_T3,
		ST_T4,
		ST_SA,
		ST_SB,
		ST_SBW,
		ST_SC,
		ST_SD,
		ST_RETIME,
		ST_EMIT,
		ST_EON,
		ST_EOFF,
		ST_EDIV,
		ST_EOUT
	} seq_state_t;

	typedef struct packed {
		logic        start;
		au_op_t      op;
		logic [31:0] a;
		logic [16:0] b;
		logic [16:0] d;
	} au_cmd_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] q;
	} au_rsp_t;

	typedef struct packed {
		logic [15:0] full_off;
		logic [15:0] fade_out;
		logic [15:0] full_on;
		logic [15:0] fade_in;
	} timing_t;

	typedef struct packed {
		logic [7:0] on;
		logic [7:0] off;
	} levels_t;

	function automatic logic [31:0] sat32(input logic [PROD_W-1:0] v);
		return (|v[PROD_W-1:32]) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

@@ rtl/lpfs_muldiv.sv @@
// Shared arithmetic unit: one 32x17 multiply, optionally followed by a restoring
// division of the 49-bit product, one quotient bit per cycle. Uses lpfs_pkg.
`include "led_pwm_fade_sequencer_core_defines.svh"

module lpfs_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  lpfs_pkg::au_cmd_t cmd,
	output lpfs_pkg::au_rsp_t rsp
);
	import lpfs_pkg::*;

	au_state_t         state_q, state_d;
	au_op_t            op_q;
	logic [31:0]       a_q;
	logic [16:0]       b_q, d_q;
	logic [PROD_W-1:0] acc_q;
	logic [16:0]       rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [17:0]       trial, diff;
	logic              take;

	always_comb begin
		trial = {rem_q, acc_q[PROD_W-1]};
		diff  = trial - {1'b0, d_q};
		take  = trial >= {1'b0, d_q};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			AU_IDLE: if (cmd.start) state_d = AU_MUL;
			AU_MUL:  state_d = (op_q == AU_OP_MULDIV) ? AU_DIV : AU_IDLE;
			AU_DIV:  if (cnt_q == DIV_LAST) state_d = AU_IDLE;
			default: state_d = AU_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AU_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == AU_MUL && op_q == AU_OP_MUL) ||
				(state_q == AU_DIV && cnt_q == DIV_LAST);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			AU_IDLE: begin
				if (cmd.start) begin
					op_q <= cmd.op;
					a_q  <= cmd.a;
					b_q  <= cmd.b;
					d_q  <= cmd.d;
				end
			end
			AU_MUL: begin
				acc_q <= {17'b0, a_q} * {32'b0, b_q};
				rem_q <= '0;
				cnt_q <= '0;
			end
			AU_DIV: begin
				acc_q <= {acc_q[PROD_W-2:0], take};
				rem_q <= take ? diff[16:0] : trial[16:0];
				cnt_q <= cnt_q + CNT_W'(1);
			end
			default: ;
		endcase
	end

	always_comb begin
		rsp.done = done_q;
		rsp.q    = acc_q;
	end

	`LPFS_ASSERT_IMPL(a_start_when_idle, cmd.start, state_q == AU_IDLE, "request while busy")
	`LPFS_ASSERT_NEXT(a_done_single, done_q, !done_q, "done longer than one cycle")
	`LPFS_ASSERT_IMPL(a_cnt_range, state_q == AU_DIV, cnt_q <= DIV_LAST, "divide step out of range")

endmodule

@@ rtl/led_pwm_fade_sequencer_core.sv @@
// Top level of the LED PWM fade sequencer: request decode, phase sequencer and
// result register. Uses lpfs_pkg and lpfs_muldiv.
`include "led_pwm_fade_sequencer_core_defines.svh"

// Breathing sequencer for up to three LED channels. A set request stores new
// colour, levels and phase times; a tick request while running converts the tick count to
// milliseconds, walks fade out, switch, fade in, full on, fade out and full off,
// and sends one duty (0 to 65025) per enabled channel, tlast on the final one
// and tuser high when the sequence halts after that tick. All multiplication
// and division runs on one shared multiply/divide unit with a 49-step restoring
// divider. A tick may switch to the pending settings, or wrap and re-time the
// count instead of sending duties; a set request re-times the count only when
// the colour changes. The block takes a new request only when the previous one
// is done; the last duty may still wait in the output register meanwhile.
module led_pwm_fade_sequencer_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [16:0]   cfg_wdata,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// bright_ch0, bright_ch1, bright_ch2, level_on, level_off,
	// fade_in_ms, full_on_ms, fade_out_ms, full_off_ms
	input  logic [103:0]  s_axis_tdata,
	// operation
	input  logic          s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// channel, duty, zero fill
	output logic [23:0]   m_axis_tdata,
	output logic          m_axis_tlast,
	// halted
	output logic          m_axis_tuser
);
	import lpfs_pkg::*;

	seq_state_t      state_q, state_d;
	logic [16:0]     rate_q, rate_eff;
	logic [2:0]      mask_q, ch_mask, above;
	logic            running_q, is_set_q, halt_q;
	logic [31:0]     count_q, ms_q;
	logic [2:0][7:0] act_col_q, pend_col_q, in_col;
	levels_t         act_lvl_q, pend_lvl_q, in_lvl;
	timing_t         act_tm_q, pend_tm_q, in_tm;
	op_t             in_op;
	logic [15:0]     num_q, den_q, on_q, off_q, duty_q, duty_calc, off_new, abs_diff;
	logic [CH_W-1:0] ch_q, out_ch_q;
	logic            out_valid_q, out_last_q, out_halt_q;
	logic [15:0]     out_duty_q;
	logic            in_acc, out_free, differ, col_chg, ch_done, ch_en, last_calc;
	logic            lt_fi, lt_fon, lt_fo, lt_foff;
	logic            emit_go, emit_halt, ms_sub_go;
	logic [15:0]     emit_num, emit_den, ms_sub;
	logic [16:0]     qs;
	logic [17:0]     sum;
	au_cmd_t         au_cmd;
	au_rsp_t         au_rsp;

	lpfs_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (au_cmd),
		.rsp    (au_rsp)
	);

	always_comb begin
		in_op       = op_t'(s_axis_tuser);
		in_col      = s_axis_tdata[23:0];
		in_lvl.on   = s_axis_tdata[31:24];
		in_lvl.off  = s_axis_tdata[39:32];
		in_tm.fade_in  = s_axis_tdata[55:40];
		in_tm.full_on  = s_axis_tdata[71:56];
		in_tm.fade_out = s_axis_tdata[87:72];
		in_tm.full_off = s_axis_tdata[103:88];

		s_axis_tready = state_q == ST_IDLE;
		in_acc   = s_axis_tvalid && s_axis_tready;
		out_free = !out_valid_q || m_axis_tready;
		rate_eff = (rate_q == '0) ? 17'd1 : rate_q;
		differ   = act_col_q != pend_col_q || act_lvl_q != pend_lvl_q || act_tm_q != pend_tm_q;
		col_chg  = in_col != act_col_q;

		lt_fi   = ms_q < {16'b0, act_tm_q.fade_in};
		lt_fon  = ms_q < {16'b0, act_tm_q.full_on};
		lt_fo   = ms_q < {16'b0, act_tm_q.fade_out};
		lt_foff = ms_q < {16'b0, act_tm_q.full_off};

		ch_done   = ch_q == CH_W'(CHANNELS);
		ch_mask   = mask_q & CH_MASK;
		ch_en     = ch_mask[ch_q];
		above     = ch_mask >> ch_q;
		last_calc = ~|above[2:1];

		off_new  = au_rsp.q[15:0];
		abs_diff = (on_q >= off_new) ? on_q - off_new : off_new - on_q;

		qs = (|au_rsp.q[PROD_W-1:17]) ? 17'h1FFFF : au_rsp.q[16:0];
		sum = {2'b0, off_q} + {1'b0, qs};
		if (on_q >= off_q)
			duty_calc = (sum > {2'b0, FULL_SCALE}) ? FULL_SCALE : sum[15:0];
		else
			duty_calc = (qs > {1'b0, off_q}) ? 16'd0 : off_q - qs[15:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_op == OP_SET)
						state_d = col_chg ? ST_MS : ST_IDLE;
					else
						state_d = running_q ? ST_MS : ST_IDLE;
				end
			end
			ST_MS:     if (au_rsp.done) state_d = is_set_q ? ST_SA : ST_T0;
			ST_T0:     state_d = lt_fo ? ST_EMIT : (differ ? ST_T0W : ST_T1);
			ST_T0W:    if (au_rsp.done) state_d = ST_T1;
			ST_T1:     state_d = (lt_fi || act_tm_q.full_off == '0) ? ST_EMIT : ST_T2;
			ST_T2:     state_d = lt_fon ? ST_EMIT : ST_T3;
			ST_T3:     state_d = (lt_fo || act_tm_q.full_on == '0) ? ST_EMIT : ST_T4;
			ST_T4:     state_d = lt_foff ? ST_EMIT : ST_RETIME;
			ST_SA:     state_d = lt_fo ? ST_RETIME : ST_SB;
			ST_SB:     state_d = lt_fi ? ST_SBW : ST_SC;
			ST_SBW:    if (au_rsp.done) state_d = ST_RETIME;
			ST_SC:     state_d = lt_fon ? ST_RETIME : ST_SD;
			ST_SD:     state_d = ST_RETIME;
			ST_RETIME: if (au_rsp.done) state_d = ST_IDLE;
			ST_EMIT: begin
				if (ch_done)
					state_d = ST_IDLE;
				else if (ch_en)
					state_d = ST_EON;
			end
			ST_EON:    if (au_rsp.done) state_d = ST_EOFF;
			ST_EOFF:   if (au_rsp.done) state_d = (den_q == '0) ? ST_EOUT : ST_EDIV;
			ST_EDIV:   if (au_rsp.done) state_d = ST_EOUT;
			ST_EOUT:   if (out_free) state_d = ST_EMIT;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		au_cmd       = '0;
		au_cmd.op    = AU_OP_MULDIV;
		au_cmd.b     = rate_eff;
		au_cmd.d     = MS_PER_S;
		emit_go      = 1'b0;
		emit_halt    = 1'b0;
		emit_num     = 16'd0;
		emit_den     = 16'd1;
		ms_sub_go    = 1'b0;
		ms_sub       = act_tm_q.fade_out;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && ((in_op == OP_SET) ? col_chg : running_q)) begin
					au_cmd.start = 1'b1;
					au_cmd.a     = count_q;
					au_cmd.b     = MS_PER_S;
					au_cmd.d     = rate_eff;
				end
			end
			ST_T0: begin
				if (lt_fo) begin
					emit_go  = 1'b1;
					emit_num = act_tm_q.fade_out - ms_q[15:0];
					emit_den = act_tm_q.fade_out;
				end else if (differ) begin
					au_cmd.start = 1'b1;
					au_cmd.a     = {16'b0, pend_tm_q.fade_out};
				end else begin
					ms_sub_go = 1'b1;
				end
			end
			ST_T1: begin
				if (lt_fi) begin
					emit_go  = 1'b1;
					emit_num = ms_q[15:0];
					emit_den = act_tm_q.fade_in;
				end else if (act_tm_q.full_off == '0) begin
					emit_go   = 1'b1;
					emit_halt = 1'b1;
					emit_num  = 16'd1;
				end else begin
					ms_sub_go = 1'b1;
					ms_sub    = act_tm_q.fade_in;
				end
			end
			ST_T2: begin
				if (lt_fon) begin
					emit_go  = 1'b1;
					emit_num = 16'd1;
				end else begin
					ms_sub_go = 1'b1;
					ms_sub    = act_tm_q.full_on;
				end
			end
			ST_T3: begin
				if (lt_fo) begin
					emit_go  = 1'b1;
					emit_num = act_tm_q.fade_out - ms_q[15:0];
					emit_den = act_tm_q.fade_out;
				end else if (act_tm_q.full_on == '0) begin
					emit_go   = 1'b1;
					emit_halt = 1'b1;
				end else begin
					ms_sub_go = 1'b1;
				end
			end
			ST_T4: begin
				if (lt_foff) begin
					emit_go = 1'b1;
				end else begin
					au_cmd.start = 1'b1;
					au_cmd.a     = {16'b0, act_tm_q.fade_out};
				end
			end
			ST_SA: begin
				if (lt_fo) begin
					au_cmd.start = 1'b1;
					au_cmd.a     = ms_q;
				end else begin
					ms_sub_go = 1'b1;
				end
			end
			ST_SB: begin
				if (lt_fi) begin
					au_cmd.start = 1'b1;
					au_cmd.a     = ms_q;
					au_cmd.b     = {1'b0, act_tm_q.fade_out};
					au_cmd.d     = {1'b0, act_tm_q.fade_in};
				end else begin
					ms_sub_go = 1'b1;
					ms_sub    = act_tm_q.fade_in;
				end
			end
			ST_SBW: begin
				if (au_rsp.done) begin
					au_cmd.start = 1'b1;
					au_cmd.a     = {16'b0, act_tm_q.fade_out} - au_rsp.q[31:0];
				end
			end
			ST_SC: begin
				if (lt_fon) begin
					au_cmd.start = 1'b1;
					au_cmd.a     = 32'd0;
				end else begin
					ms_sub_go = 1'b1;
					ms_sub    = act_tm_q.full_on;
				end
			end
			ST_SD: begin
				au_cmd.start = 1'b1;
				au_cmd.a     = lt_fo ? ms_q : {16'b0, act_tm_q.fade_out};
			end
			ST_EMIT: begin
				if (!ch_done && ch_en) begin
					au_cmd.start = 1'b1;
					au_cmd.op    = AU_OP_MUL;
					au_cmd.a     = {24'b0, act_col_q[ch_q]};
					au_cmd.b     = {9'b0, act_lvl_q.on};
				end
			end
			ST_EON: begin
				if (au_rsp.done) begin
					au_cmd.start = 1'b1;
					au_cmd.op    = AU_OP_MUL;
					au_cmd.a     = {24'b0, act_col_q[ch_q]};
					au_cmd.b     = {9'b0, act_lvl_q.off};
				end
			end
			ST_EOFF: begin
				if (au_rsp.done && den_q != '0) begin
					au_cmd.start = 1'b1;
					au_cmd.a     = {16'b0, abs_diff};
					au_cmd.b     = {1'b0, num_q};
					au_cmd.d     = {1'b0, den_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rate_q      <= RATE_RESET;
			mask_q      <= MASK_RESET;
			running_q   <= 1'b0;
			is_set_q    <= 1'b0;
			halt_q      <= 1'b0;
			count_q     <= '0;
			act_col_q   <= '0;
			pend_col_q  <= '0;
			act_lvl_q   <= '0;
			pend_lvl_q  <= '0;
			act_tm_q    <= '0;
			pend_tm_q   <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_TICK_RATE: rate_q <= cfg_wdata;
					CFG_CHAN_MASK: mask_q <= cfg_wdata[2:0];
					default: ;
				endcase
			end
			if (state_q == ST_EOUT && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready)
				out_valid_q <= 1'b0;
			if (emit_go) begin
				ch_q   <= '0;
				halt_q <= emit_halt;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						is_set_q <= in_op == OP_SET;
						if (in_op == OP_SET) begin
							pend_col_q <= in_col;
							pend_lvl_q <= in_lvl;
							pend_tm_q  <= in_tm;
							running_q  <= 1'b1;
						end else if (running_q) begin
							count_q <= count_q + 32'd1;
						end
					end
				end
				ST_T0: begin
					if (!lt_fo && differ) begin
						act_col_q <= pend_col_q;
						act_lvl_q <= pend_lvl_q;
						act_tm_q  <= pend_tm_q;
					end
				end
				ST_T0W, ST_RETIME: if (au_rsp.done) count_q <= sat32(au_rsp.q);
				ST_EMIT: begin
					if (ch_done) begin
						if (halt_q)
							running_q <= 1'b0;
					end else if (!ch_en) begin
						ch_q <= ch_q + CH_W'(1);
					end
				end
				ST_EOUT: begin
					if (out_free)
						ch_q <= ch_q + CH_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			num_q <= emit_num;
			den_q <= emit_den;
		end
		if (ms_sub_go)
			ms_q <= ms_q - {16'b0, ms_sub};
		case (state_q)
			ST_MS: if (au_rsp.done) ms_q <= sat32(au_rsp.q);
			ST_T0: if (!lt_fo && differ) ms_q <= '0;
			ST_EON: if (au_rsp.done) on_q <= au_rsp.q[15:0];
			ST_EOFF: begin
				if (au_rsp.done) begin
					off_q  <= off_new;
					duty_q <= off_new;
				end
			end
			ST_EDIV: if (au_rsp.done) duty_q <= duty_calc;
			ST_EOUT: begin
				if (out_free) begin
					out_ch_q   <= ch_q;
					out_duty_q <= duty_q;
					out_last_q <= last_calc;
					out_halt_q <= halt_q;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		m_axis_tvalid = out_valid_q;
		m_axis_tdata  = {6'b0, out_duty_q, out_ch_q};
		m_axis_tlast  = out_last_q;
		m_axis_tuser  = out_halt_q;
	end

	`LPFS_ASSERT_IMPL(a_idle_unit_quiet, s_axis_tready, !au_rsp.done, "unit result while idle")
	`LPFS_ASSERT_IMPL(a_duty_range, m_axis_tvalid, out_duty_q <= FULL_SCALE, "duty above full scale")
	`LPFS_ASSERT_IMPL(a_ch_range, 1'b1, ch_q <= CH_W'(CHANNELS), "channel counter out of range")

endmodule
